>>> rtl/tssw_pkg.sv
// Package for the two-sided span window block: sizes, field widths, the
// controller state type and the structs passed between the top level and the cells.
// No dependencies.
package tssw_pkg;

  localparam int MAX_CITIES  = 64;
  localparam int HEIGHT_BITS = 16;

  // Index into the row of cells, and a count that can hold MAX_CITIES itself.
  localparam int IDX_W = (MAX_CITIES > 1) ? $clog2(MAX_CITIES) : 1;
  localparam int CNT_W = $clog2(MAX_CITIES + 1);

  // Fixed widths of the stream fields.
  localparam int IN_H_W      = 16;
  localparam int POS_W       = 6;
  localparam int SPAN_W      = 7;
  localparam int OUT_TDATA_W = 16;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_START,
    ST_STEP,
    ST_FOLD,
    ST_EMIT
  } state_t;

  // Commands broadcast to every cell.
  typedef struct packed {
    logic start;
    logic step;
    logic fold;
    logic shift;
    logic clear;
  } cell_ctrl_t;

  // One height travelling along the row; an invalid entry acts as a wall.
  typedef struct packed {
    logic                   valid;
    logic [HEIGHT_BITS-1:0] h;
  } stream_t;

endpackage

>>> rtl/tssw_cell.sv
// One cell of the span row: holds one height, the two travelling heights and
// the left and right window counts. Depends on tssw_pkg.
module tssw_cell
  import tssw_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  cell_ctrl_t             ctrl,
  input  logic                   wr_en,
  input  logic [HEIGHT_BITS-1:0] wr_height,
  input  stream_t                left_in,
  input  stream_t                right_in,
  input  logic [CNT_W-1:0]       span_in,
  output stream_t                left_out,
  output stream_t                right_out,
  output logic [CNT_W-1:0]       span_out
);

  logic                   vld;
  logic [HEIGHT_BITS-1:0] h;
  stream_t                lstr;
  stream_t                rstr;
  logic [CNT_W-1:0]       lcnt;
  logic [CNT_W-1:0]       rcnt;
  logic                   lopen;
  logic                   ropen;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (wr_en) begin
      vld <= 1'b1;
    end else if (ctrl.clear) begin
      vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      h <= wr_height;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      lstr  <= '{valid: vld, h: h};
      rstr  <= '{valid: vld, h: h};
      lcnt  <= CNT_W'(1);
      rcnt  <= '0;
      lopen <= 1'b1;
      ropen <= 1'b1;
    end else if (ctrl.step) begin
      // Heights from the left move right and heights from the right move left;
      // each side stops counting at the first strictly higher height or a wall.
      lstr <= left_in;
      rstr <= right_in;
      if (lopen) begin
        if (left_in.valid && (left_in.h <= h)) begin
          lcnt <= lcnt + CNT_W'(1);
        end else begin
          lopen <= 1'b0;
        end
      end
      if (ropen) begin
        if (right_in.valid && (right_in.h <= h)) begin
          rcnt <= rcnt + CNT_W'(1);
        end else begin
          ropen <= 1'b0;
        end
      end
    end else if (ctrl.fold) begin
      lcnt <= lcnt + rcnt;
    end else if (ctrl.shift) begin
      lcnt <= span_in;
    end
  end

  assign left_out  = lstr;
  assign right_out = rstr;
  assign span_out  = lcnt;

endmodule

>>> rtl/two_sided_span_window.sv
// Top level of the two-sided span window block: controller, load logic and
// the row of tssw_cell instances. Depends on tssw_pkg and tssw_cell.
//
//   Channel | Direction | Handshake        | Item contents
//   --------+-----------+------------------+-----------------------------------------
//   s_      | in        | s_tvalid/s_tready| s_tdata = height, s_tlast = last of set
//   m_      | out       | m_tvalid/m_tready| m_tdata = position, span_width;
//           |           |                  | m_tuser = overflow, m_tlast = final_res
//
// Loading accepts an item whenever s_tvalid is high. After the item marked
// last, the block seeds the row (ST_START), lets heights travel one cell per
// cycle in both directions (ST_STEP) and adds the two counts (ST_FOLD). It then
// gives one span per loaded position, one per cycle while m_tready is high, by
// shifting the finished spans towards cell 0.
// Reset clears the controller, the fill count, the overflow flag and the cell
// valid bits; no clearing pass is needed. Input is taken only while loading,
// and a stall on the output simply holds the head of the row.
module two_sided_span_window
  import tssw_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_H_W-1:0]      s_tdata,   // [15:0] height
  input  logic                   s_tlast,   // last
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // [5:0] position, [12:6] span_width, rest zero
  output logic                   m_tuser,   // overflow
  output logic                   m_tlast    // final_res
);

  state_t            state;
  state_t            state_next;
  cell_ctrl_t        ctrl;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  step_cnt;
  logic [IDX_W-1:0]  pos;
  logic              dropped;

  logic              in_acc;
  logic              out_acc;
  logic              room;
  logic              is_final;
  logic              steps_done;

  stream_t           lchain [MAX_CITIES];
  stream_t           rchain [MAX_CITIES];
  logic [CNT_W-1:0]  schain [MAX_CITIES];

  assign in_acc     = s_tvalid && s_tready;
  assign out_acc    = m_tvalid && m_tready;
  assign room       = (count < CNT_W'(MAX_CITIES));
  assign is_final   = ((CNT_W'(pos) + CNT_W'(1)) == count);
  assign steps_done = (step_cnt == CNT_W'(MAX_CITIES - 1));

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD: begin
        if (in_acc && s_tlast) begin
          state_next = ST_START;
        end
      end
      ST_START: begin
        state_next = ST_STEP;
      end
      ST_STEP: begin
        if (steps_done) begin
          state_next = ST_FOLD;
        end
      end
      ST_FOLD: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_acc && is_final) begin
          state_next = ST_LOAD;
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  // Outputs of the controller. While emitting, m_tvalid is high, so an item
  // leaves exactly when m_tready is high.
  always_comb begin
    ctrl     = '0;
    s_tready = 1'b0;
    m_tvalid = 1'b0;
    unique case (state)
      ST_LOAD: begin
        s_tready = 1'b1;
      end
      ST_START: begin
        ctrl.start = 1'b1;
      end
      ST_STEP: begin
        ctrl.step = 1'b1;
      end
      ST_FOLD: begin
        ctrl.fold = 1'b1;
      end
      ST_EMIT: begin
        m_tvalid   = 1'b1;
        ctrl.shift = m_tready;
        ctrl.clear = m_tready && is_final;
      end
      default: begin
        ctrl = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_LOAD;
      count    <= '0;
      dropped  <= 1'b0;
      pos      <= '0;
      step_cnt <= '0;
    end else begin
      state <= state_next;
      if (in_acc) begin
        if (room) begin
          count <= count + CNT_W'(1);
        end else begin
          dropped <= 1'b1;
        end
      end
      if (ctrl.start) begin
        step_cnt <= '0;
      end else if (ctrl.step) begin
        step_cnt <= step_cnt + CNT_W'(1);
      end
      if (out_acc) begin
        if (is_final) begin
          pos     <= '0;
          count   <= '0;
          dropped <= 1'b0;
        end else begin
          pos <= pos + IDX_W'(1);
        end
      end
    end
  end

  // The row of cells. Heights from the left wall enter cell 0 as invalid, and
  // those from the right wall enter the last cell as invalid; cells beyond the
  // loaded count are invalid too and so also act as the right wall.
  for (genvar i = 0; i < MAX_CITIES; i++) begin : g_cell
    stream_t          left_in;
    stream_t          right_in;
    logic [CNT_W-1:0] span_in;
    logic             wr_en;

    assign wr_en = in_acc && room && (count[IDX_W-1:0] == IDX_W'(i));

    if (i == 0) begin : g_first
      assign left_in = '0;
    end else begin : g_inner_l
      assign left_in = lchain[i-1];
    end

    if (i == MAX_CITIES - 1) begin : g_last
      assign right_in = '0;
      assign span_in  = '0;
    end else begin : g_inner_r
      assign right_in = rchain[i+1];
      assign span_in  = schain[i+1];
    end

    tssw_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .wr_en     (wr_en),
      .wr_height (s_tdata[HEIGHT_BITS-1:0]),
      .left_in   (left_in),
      .right_in  (right_in),
      .span_in   (span_in),
      .left_out  (lchain[i]),
      .right_out (rchain[i]),
      .span_out  (schain[i])
    );
  end

  // While emitting, cell 0 holds the span of the position due next.
  assign m_tdata = {(OUT_TDATA_W - POS_W - SPAN_W)'(0), SPAN_W'(schain[0]), POS_W'(pos)};
  assign m_tuser = dropped;
  assign m_tlast = is_final;

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for two_sided_span_window: sets of heights go in and
// each span result is checked. It depends only on tssw_pkg and the block itself.

module testbench;
  import tssw_pkg::*;

  // A long run of cycles without any item moving on either side ends the run.
  // The longest legitimate quiet stretch is the receiver hold-off below.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 200;
  localparam int HOLD_AFTER     = 40;    // spans seen before the long hold-off
  localparam int RANDOM_ITEMS   = 145;
  localparam int CALM_FROM      = 135;   // a set reaching this many random items has no idling
  localparam int FULL_SET       = MAX_CITIES;
  localparam int OVER_SET       = MAX_CITIES + 2;

  // Predicts the spans of each set and checks the block's results in order.
  class span_scoreboard;
    typedef struct packed {
      logic [POS_W-1:0]  position;
      logic [SPAN_W-1:0] span_width;
      logic              overflow;
      logic              final_res;
    } span_result_t;

    logic [IN_H_W-1:0] held_heights[$];
    bit                dropped;
    span_result_t      pending_spans[$];
    int                sets_done;
    int                items_seen;
    int                spans_seen;
    int                overflow_sets;
    int                longest_set;
    int                mismatches;

    function int pending();
      return pending_spans.size();
    endfunction

    // Nearest strictly higher neighbour on each side by two stack sweeps;
    // the walls past both ends count as infinitely high.
    function void predict_set();
      int           m;
      int           stack[$];
      int           span[MAX_CITIES];
      span_result_t r;
      m = held_heights.size();
      for (int i = 0; i < m; i++) begin
        while (stack.size() > 0 && held_heights[stack[$]] <= held_heights[i])
          void'(stack.pop_back());
        span[i] = (stack.size() > 0) ? i - stack[$] : i + 1;
        stack.push_back(i);
      end
      stack.delete();
      for (int i = m - 1; i >= 0; i--) begin
        while (stack.size() > 0 && held_heights[stack[$]] <= held_heights[i])
          void'(stack.pop_back());
        span[i] += (stack.size() > 0) ? stack[$] - i - 1 : m - 1 - i;
        stack.push_back(i);
      end
      for (int k = 0; k < m; k++) begin
        r.position   = POS_W'(k);
        r.span_width = SPAN_W'(span[k]);
        r.overflow   = dropped;
        r.final_res  = (k == m - 1);
        pending_spans.push_back(r);
      end
      sets_done++;
      if (dropped) overflow_sets++;
      if (m > longest_set) longest_set = m;
      held_heights.delete();
      dropped = 1'b0;
    endfunction

    // An accepted input item: stored while there is room, otherwise dropped
    // and flagged. The last item closes the set even when it is dropped.
    function void note_item(logic [IN_H_W-1:0] h, logic last);
      items_seen++;
      if (held_heights.size() < MAX_CITIES) held_heights.push_back(h);
      else dropped = 1'b1;
      if (last) predict_set();
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] data, logic user, logic last);
      span_result_t want;
      spans_seen++;
      if (pending_spans.size() == 0) begin
        $error("span result with nothing expected: position %0d span_width %0d",
               data[POS_W-1:0], data[POS_W+SPAN_W-1:POS_W]);
        mismatches++;
        return;
      end
      want = pending_spans.pop_front();
      if (data[POS_W-1:0] !== want.position) begin
        $error("position: expected %0d, got %0d", want.position, data[POS_W-1:0]);
        mismatches++;
      end
      if (data[POS_W+SPAN_W-1:POS_W] !== want.span_width) begin
        $error("span_width: expected %0d, got %0d", want.span_width,
               data[POS_W+SPAN_W-1:POS_W]);
        mismatches++;
      end
      if (user !== want.overflow) begin
        $error("overflow: expected %0d, got %0d", want.overflow, user);
        mismatches++;
      end
      if (last !== want.final_res) begin
        $error("final_res: expected %0d, got %0d", want.final_res, last);
        mismatches++;
      end
    endfunction
  endclass

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_H_W-1:0]      s_tdata;   // [15:0] height
  logic                   s_tlast;   // last
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;   // [5:0] position, [12:6] span_width, rest zero
  logic                   m_tuser;   // overflow
  logic                   m_tlast;   // final_res

  span_scoreboard sb;
  bit             calm;        // set near the end: neither side idles any more
  bit             steady;      // per set: the sender offers without gaps
  bit             hold_done;
  int             quiet_cycles;

  two_sided_span_window dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Offers one item from a falling edge and holds it until the block takes it.
  // Before the item there may be a random gap with tvalid low; between items
  // that follow one another tvalid simply stays high.
  task automatic send_item(input logic [IN_H_W-1:0] h, input logic last);
    int gap;
    @(negedge clk);
    if (!calm && !steady && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = h;
    s_tlast  = last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // One set of n heights with a random shape. Ties and ramps matter as much
  // as random values, since only a strictly higher neighbour bounds a window.
  task automatic send_set(input int n);
    int                shape;
    logic [IN_H_W-1:0] base;
    logic [IN_H_W-1:0] stride;
    logic [IN_H_W-1:0] h;
    shape  = $urandom_range(0, 4);
    base   = IN_H_W'($urandom_range(0, 65535));
    stride = IN_H_W'($urandom_range(0, 300));
    steady = ($urandom_range(0, 2) == 0);
    for (int i = 0; i < n; i++) begin
      case (shape)
        0: h = IN_H_W'($urandom_range(0, 65535));
        1: h = IN_H_W'($urandom_range(0, 3));
        2: h = base + IN_H_W'(i) * stride;
        3: h = base - IN_H_W'(i) * stride;
        default: h = ($urandom_range(0, 1) == 1) ? 16'hFFFF
                                                 : IN_H_W'($urandom_range(0, 65535));
      endcase
      send_item(h, i == n - 1);
    end
  endtask

  // The receiver: short random stalls, and once in the run a long hold-off
  // while the sender keeps offering, so that the block fills up and stops
  // taking input. Each value is set at a falling edge.
  initial begin
    int stall;
    m_tready  = 1'b0;
    hold_done = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!hold_done && sb.spans_seen >= HOLD_AFTER) begin
        m_tready  = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_done = 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall    = $urandom_range(1, 10);
        m_tready = 1'b0;
        repeat (stall - 1) @(negedge clk);
      end else begin
        m_tready = 1'b1;
      end
      @(negedge clk);
    end
  end

  // Sampling at the rising edge: accepted results are checked, accepted
  // input items go to the predictor, and the watchdog counts quiet cycles.
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles = 0;
    end else begin
      if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser, m_tlast);
      if (s_tvalid && s_tready) sb.note_item(s_tdata, s_tlast);
      if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("two_sided_span_window test failed");
        $finish;
      end
    end
  end

  // Directed sets: a lone lowest and a lone highest height, a run of ties,
  // a rising ramp, the extremes mixed, and equal peaks that must not bound
  // each other.
  logic [IN_H_W-1:0] directed_h[21] = '{
    16'h0000,
    16'hFFFF,
    16'd7, 16'd7, 16'd7,
    16'd1, 16'd2, 16'd3, 16'd4,
    16'hFFFF, 16'h0000, 16'hFFFF, 16'h8000, 16'h0000, 16'h5555, 16'hAAAA,
    16'd5, 16'd9, 16'd5, 16'd9, 16'd5
  };
  logic directed_last[21] = '{
    1'b1,
    1'b1,
    1'b0, 1'b0, 1'b1,
    1'b0, 1'b0, 1'b0, 1'b1,
    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
    1'b0, 1'b0, 1'b0, 1'b0, 1'b1
  };

  initial begin
    int random_items;
    int set_no;
    int n;
    sb       = new();
    calm     = 1'b0;
    steady   = 1'b0;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tlast  = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int i = 0; i < 21; i++) send_item(directed_h[i], directed_last[i]);

    // Random sets, mostly short. The first goes past the store, so that a
    // plain item and the closing item are dropped, and a later one fills it
    // exactly. The closing sets run with no idling on either side.
    random_items = 0;
    set_no       = 0;
    while (random_items < RANDOM_ITEMS) begin
      if (set_no == 0) n = OVER_SET;
      else if (set_no == 2) n = FULL_SET;
      else n = $urandom_range(1, 12);
      if (random_items + n >= CALM_FROM) calm = 1'b1;
      send_set(n);
      random_items += n;
      set_no++;
    end

    @(negedge clk);
    s_tvalid = 1'b0;
    s_tlast  = 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    // Linger for longer than a compute pass to catch stray results.
    repeat (MAX_CITIES + 8) @(posedge clk);

    $display("Ran %0d sets of heights (%0d items in, %0d spans out); %0d sets overflowed.",
             sb.sets_done, sb.items_seen, sb.spans_seen, sb.overflow_sets);
    $display("Longest set held %0d positions; one output hold-off of %0d cycles.",
             sb.longest_set, HOLD_CYCLES);
    if (sb.mismatches == 0) begin
      $display("two_sided_span_window test passed");
    end else begin
      $display("two_sided_span_window test failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/tssw_pkg.sv
rtl/tssw_cell.sv
rtl/two_sided_span_window.sv
dv/testbench.sv
